@@ hdl/icpc_pkg.sv @@
// ----------------------------------------------------------------------------
// icpc_pkg
// Shared types and constants for the ICMP probe reply classifier.
// ----------------------------------------------------------------------------
package icpc_pkg;

   localparam int COUNT_W = 11;
   localparam int HDR_W   = 6;

   localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(1500);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [15:0] PROBE_PORT_RESET = 16'd33434;

   localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
   localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
   localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;

   // Offsets inside the ICMP message, counted from the end of the outer header
   localparam logic [COUNT_W-1:0] OFS_CODE       = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] OFS_INNER      = COUNT_W'(8);
   localparam logic [COUNT_W-1:0] OFS_PORT_HI    = COUNT_W'(10);
   localparam logic [COUNT_W-1:0] OFS_PORT_LO    = COUNT_W'(11);
   localparam logic [COUNT_W-1:0] MIN_ICMP_BYTES = COUNT_W'(28);
   localparam logic [COUNT_W-1:0] QUOTE_BYTES    = COUNT_W'(16);

   typedef enum logic [1:0] {
      VERDICT_IGNORE        = 2'd0,
      VERDICT_TIME_EXCEEDED = 2'd1,
      VERDICT_PORT_UNREACH  = 2'd2,
      VERDICT_OTHER_UNREACH = 2'd3
   } verdict_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } stage_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  reply_code;
   } result_type;

endpackage

@@ hdl/icpc_if.sv @@
// ----------------------------------------------------------------------------
// icpc_if
// Valid/ready channels for packet bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface icpc_req_if
   import icpc_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icpc_rsp_if
   import icpc_pkg::*;
();
   logic        valid;
   logic        ready;
   verdict_type verdict;
   logic [7:0]  reply_code;

   modport source (output valid, output verdict, output reply_code, input ready);
   modport sink   (input valid, input verdict, input reply_code, output ready);
endinterface

@@ hdl/icpc_in_stage.sv @@
// ----------------------------------------------------------------------------
// icpc_in_stage
// Input register for one packet byte; advances when the parser can take it.
// ----------------------------------------------------------------------------
module icpc_in_stage
   import icpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic [7:0] req_data_byte,
   input  logic      req_last_byte,
   input  logic      out_free,
   output stage_type stage,
   output logic      advance
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;

   // A non-final byte yields no result, so it never waits on the output side
   assign advance   = valid_ff && (!last_ff || out_free);
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   assign stage = '{valid: valid_ff, data_byte: data_ff, last_byte: last_ff};

endmodule

@@ hdl/icpc_parser.sv @@
// ----------------------------------------------------------------------------
// icpc_parser
// Per-packet field capture and verdict logic for one byte per cycle while bytes advance.
// ----------------------------------------------------------------------------
module icpc_parser
   import icpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  stage_type   stage,
   input  logic [15:0] probe_port,
   output result_type  result
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [HDR_W-1:0]   outer_ff, outer_in;
   logic [7:0]         type_ff, type_in;
   logic [7:0]         code_ff, code_in;
   logic [HDR_W-1:0]   inner_ff, inner_in;
   logic [15:0]        port_ff, port_in;

   logic               parse_en;
   logic [HDR_W-1:0]   hdr_len;
   logic [COUNT_W-1:0] outer_pos;
   logic [COUNT_W-1:0] quote_pos;
   logic [COUNT_W-1:0] count_nxt;
   logic [COUNT_W-1:0] eff_len;
   logic               accept_reply;
   logic [HDR_W-1:0]   outer_nxt;
   logic [7:0]         type_nxt;
   logic [7:0]         code_nxt;
   logic [HDR_W-1:0]   inner_nxt;
   logic [15:0]        port_nxt;

   assign parse_en = count_ff < MAX_BYTES;
   assign hdr_len  = {stage.data_byte[3:0], 2'b00};

   // The outer length taken at byte 0 already applies to this byte
   assign outer_nxt = (parse_en && count_ff == '0) ? hdr_len : outer_ff;
   assign outer_pos = COUNT_W'(outer_nxt);
   assign quote_pos = outer_pos + OFS_INNER + COUNT_W'(inner_ff);

   always_comb begin
      type_nxt  = type_ff;
      code_nxt  = code_ff;
      inner_nxt = inner_ff;
      port_nxt  = port_ff;
      if (parse_en) begin
         if (count_ff == outer_pos) begin
            type_nxt = stage.data_byte;
         end
         if (count_ff == outer_pos + OFS_CODE) begin
            code_nxt = stage.data_byte;
         end
         if (count_ff == outer_pos + OFS_INNER) begin
            inner_nxt = hdr_len;
         end
         if (count_ff == quote_pos + (OFS_PORT_HI - OFS_INNER)) begin
            port_nxt[15:8] = stage.data_byte;
         end
         if (count_ff == quote_pos + (OFS_PORT_LO - OFS_INNER)) begin
            port_nxt[7:0] = stage.data_byte;
         end
      end
   end

   assign count_nxt = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign eff_len   = (count_nxt < MAX_BYTES) ? count_nxt : MAX_BYTES;

   assign accept_reply = (eff_len >= outer_pos + MIN_ICMP_BYTES)
                      && (type_nxt == TYPE_TIME_EXCEEDED || type_nxt == TYPE_DEST_UNREACH)
                      && (outer_pos + QUOTE_BYTES + COUNT_W'(inner_nxt) <= eff_len)
                      && (port_nxt == probe_port);

   always_comb begin
      result.verdict    = VERDICT_IGNORE;
      result.reply_code = '0;
      if (accept_reply) begin
         priority if (type_nxt == TYPE_TIME_EXCEEDED) begin
            result.verdict = VERDICT_TIME_EXCEEDED;
         end else if (code_nxt == CODE_PORT_UNREACH) begin
            result.verdict = VERDICT_PORT_UNREACH;
         end else begin
            result.verdict    = VERDICT_OTHER_UNREACH;
            result.reply_code = code_nxt;
         end
      end
   end

   // Clear all packet state after the final byte
   always_comb begin
      count_in = count_ff;
      outer_in = outer_ff;
      type_in  = type_ff;
      code_in  = code_ff;
      inner_in = inner_ff;
      port_in  = port_ff;
      if (advance) begin
         if (stage.last_byte) begin
            count_in = '0;
            outer_in = '0;
            type_in  = '0;
            code_in  = '0;
            inner_in = '0;
            port_in  = '0;
         end else begin
            count_in = count_nxt;
            outer_in = outer_nxt;
            type_in  = type_nxt;
            code_in  = code_nxt;
            inner_in = inner_nxt;
            port_in  = port_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         outer_ff <= '0;
         type_ff  <= '0;
         code_ff  <= '0;
         inner_ff <= '0;
         port_ff  <= '0;
      end else begin
         count_ff <= count_in;
         outer_ff <= outer_in;
         type_ff  <= type_in;
         code_ff  <= code_in;
         inner_ff <= inner_in;
         port_ff  <= port_in;
      end
   end

endmodule

@@ hdl/icpc_out_stage.sv @@
// ----------------------------------------------------------------------------
// icpc_out_stage
// Result register holding one verdict until the consumer takes it.
// ----------------------------------------------------------------------------
module icpc_out_stage
   import icpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   output logic        out_free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output verdict_type rsp_verdict,
   output logic [7:0]  rsp_reply_code
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_verdict    = result_ff.verdict;
   assign rsp_reply_code = result_ff.reply_code;

endmodule

@@ hdl/icmp_probe_reply_classifier.sv @@
// ----------------------------------------------------------------------------
// icmp_probe_reply_classifier
// Parses an IPv4/ICMP packet a byte at a time and classifies probe replies.
// ----------------------------------------------------------------------------
//  channel   | direction | payload                         | item
//  req_port  | in        | data_byte[7:0], last_byte       | one packet byte
//  rsp_port  | out       | verdict[1:0], reply_code[7:0]   | one verdict per packet
//  csr_*     | in        | csr_write_data[15:0]            | probe port
//
//  One byte is accepted every cycle while no final byte is held; its verdict,
//  on the final byte, passes the input register, then the result register.
//  Field capture and verdict compares sit in one pass between the registers.
//  A waiting verdict holds only a final byte in the input register, and with it
//  the input; other bytes keep flowing.
//  Reset clears all packet state and sets the probe port to 33434.
// ----------------------------------------------------------------------------
module icmp_probe_reply_classifier
   import icpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   icpc_req_if.sink    req_port,
   icpc_rsp_if.source  rsp_port,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic [15:0] probe_port_ff, probe_port_in;
   stage_type   stage;
   logic        advance;
   logic        out_free;
   logic        load;
   result_type  result;

   assign probe_port_in = csr_write_enable ? csr_write_data : probe_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_port_ff <= PROBE_PORT_RESET;
      end else begin
         probe_port_ff <= probe_port_in;
      end
   end

   icpc_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req_ready     (req_port.ready),
      .req_data_byte (req_port.data_byte),
      .req_last_byte (req_port.last_byte),
      .out_free      (out_free),
      .stage         (stage),
      .advance       (advance)
   );

   icpc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .stage      (stage),
      .probe_port (probe_port_ff),
      .result     (result)
   );

   assign load = advance && stage.last_byte;

   icpc_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .result         (result),
      .out_free       (out_free),
      .rsp_valid      (rsp_port.valid),
      .rsp_ready      (rsp_port.ready),
      .rsp_verdict    (rsp_port.verdict),
      .rsp_reply_code (rsp_port.reply_code)
   );

   // A new verdict only follows a final byte leaving the input register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_port.valid) |-> $past(advance && stage.last_byte))
      else $error("verdict raised without a final byte");

   // The code is only reported for other unreachable replies
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.verdict != VERDICT_OTHER_UNREACH)
         |-> rsp_port.reply_code == 8'd0)
      else $error("reply code set for a verdict that carries none");

   // A held byte stays put until the parser takes it
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && !advance) |=> (stage.valid && $stable(stage.data_byte)
         && $stable(stage.last_byte)))
      else $error("stalled byte lost or changed");

endmodule
